### hw/rtl/rpam_pkg.sv
// Shared types, widths and register codes for the rotation address mapper.
`default_nettype none

package rpam_pkg;

	// Field widths of the interface
	localparam int COORD_W   = 12;
	localparam int DIM_W     = 13;
	localparam int COEF_W    = 16;
	localparam int PIX_W     = 16;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 16;

	// Fixed-point format of the coefficients and the largest frame side
	localparam int FRAC_BITS = 14;
	localparam int MAX_DIM   = 4096;

	// Datapath widths
	localparam int OFS_W  = COORD_W + 1;        // signed offset from the center
	localparam int PROD_W = OFS_W + COEF_W;     // one offset times one coefficient
	localparam int SUM_W  = PROD_W + 1;         // rotated offset
	localparam int T_W    = SUM_W + 1;          // center minus rotated offset, scaled
	localparam int D_W    = T_W - FRAC_BITS;    // destination coordinate, signed
	localparam int PAD_W  = T_W - COORD_W - FRAC_BITS;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COS    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SIN    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(3);

	// Reset values
	localparam logic [COEF_W-1:0] COS_RESET = COEF_W'(1 << FRAC_BITS);
	localparam logic [COEF_W-1:0] SIN_RESET = '0;
	localparam logic [DIM_W-1:0]  DIM_RESET = DIM_W'(MAX_DIM);

	// Configuration seen by the datapath
	typedef struct packed {
		logic [COEF_W-1:0] cos_v;
		logic [COEF_W-1:0] sin_v;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
	} rpam_cfg_t;

	// Frame sides keep their low 13 bits, which saturate above the largest size
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DAT_W-1:0] v);
		logic [DIM_W-1:0] d;
		d = v[DIM_W-1:0];
		return (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/rpam_cfg.sv
// Configuration register file: rotation coefficients and frame size.
`default_nettype none

module rpam_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [rpam_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [rpam_pkg::CFG_DAT_W-1:0]    cfg_data,
	output rpam_pkg::rpam_cfg_t                    cfg
);
	import rpam_pkg::*;

	rpam_cfg_t cfg_q;

	// Writes are always taken
	assign cfg_ready = 1'b1;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cos_v  <= COS_RESET;
			cfg_q.sin_v  <= SIN_RESET;
			cfg_q.width  <= DIM_RESET;
			cfg_q.height <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COS:    cfg_q.cos_v  <= cfg_data[COEF_W-1:0];
				REG_SIN:    cfg_q.sin_v  <= cfg_data[COEF_W-1:0];
				REG_WIDTH:  cfg_q.width  <= clamp_dim(cfg_data);
				REG_HEIGHT: cfg_q.height <= clamp_dim(cfg_data);
				default:    ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/rpam_pipe.sv
// Five-stage datapath: offset, multiply, rotate, truncate, bounds check.
`default_nettype none

module rpam_pipe (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire rpam_pkg::rpam_cfg_t            cfg,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [rpam_pkg::COORD_W-1:0]   src_row,
	input  wire logic [rpam_pkg::COORD_W-1:0]   src_col,
	input  wire logic [rpam_pkg::PIX_W-1:0]     pixel_in,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [rpam_pkg::COORD_W-1:0]        dst_row,
	output logic [rpam_pkg::COORD_W-1:0]        dst_col,
	output logic [rpam_pkg::PIX_W-1:0]          pixel_out,
	output logic                                write_valid
);
	import rpam_pkg::*;

	// Per-stage valid bits and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	// Stage payloads
	logic signed [OFS_W-1:0]  ox_s1, oy_s1;
	logic [PIX_W-1:0]         pix_s1, pix_s2, pix_s3, pix_s4;
	logic signed [PROD_W-1:0] p_xc_s2, p_ys_s2, p_yc_s2, p_xs_s2;
	logic signed [T_W-1:0]    tc_s3, tr_s3;
	logic signed [D_W-1:0]    dc_s4, dr_s4;
	logic [COORD_W-1:0]       dst_row_s5, dst_col_s5;
	logic [PIX_W-1:0]         pix_s5;
	logic                     wr_s5;

	// Combinational terms between stages
	logic [COORD_W-1:0]       half_w, half_h;
	logic signed [COEF_W-1:0] cos_s, sin_s;
	logic signed [SUM_W-1:0]  nx, ny;
	logic signed [T_W-1:0]    cw_sc, ch_sc;
	logic signed [T_W-1:0]    tc_adj, tr_adj;
	logic                     row_ok, col_ok;

	// A stage moves when it is empty or the next one moves
	assign en5      = !v_s5 || !out_stall;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// Frame center and signed coefficients
	assign half_w = cfg.width[DIM_W-1:1];
	assign half_h = cfg.height[DIM_W-1:1];
	assign cos_s  = $signed(cfg.cos_v);
	assign sin_s  = $signed(cfg.sin_v);

	// Stage 1: offsets from the center
	always_ff @(posedge clk) begin
		if (en1) begin
			ox_s1  <= $signed({1'b0, half_w}) - $signed({1'b0, src_col});
			oy_s1  <= $signed({1'b0, half_h}) - $signed({1'b0, src_row});
			pix_s1 <= pixel_in;
		end
	end

	// Stage 2: four products
	always_ff @(posedge clk) begin
		if (en2) begin
			p_xc_s2 <= ox_s1 * cos_s;
			p_ys_s2 <= oy_s1 * sin_s;
			p_yc_s2 <= oy_s1 * cos_s;
			p_xs_s2 <= ox_s1 * sin_s;
			pix_s2  <= pix_s1;
		end
	end

	// Stage 3: rotated offsets subtracted from the scaled center
	assign nx    = SUM_W'(p_xc_s2) - SUM_W'(p_ys_s2);
	assign ny    = SUM_W'(p_yc_s2) + SUM_W'(p_xs_s2);
	assign cw_sc = $signed({{PAD_W{1'b0}}, half_w, {FRAC_BITS{1'b0}}});
	assign ch_sc = $signed({{PAD_W{1'b0}}, half_h, {FRAC_BITS{1'b0}}});

	always_ff @(posedge clk) begin
		if (en3) begin
			tc_s3  <= cw_sc - T_W'(nx);
			tr_s3  <= ch_sc - T_W'(ny);
			pix_s3 <= pix_s2;
		end
	end

	// Stage 4: divide by the fixed-point scale, rounding toward zero
	assign tc_adj = tc_s3[T_W-1] ? tc_s3 + T_W'((1 << FRAC_BITS) - 1) : tc_s3;
	assign tr_adj = tr_s3[T_W-1] ? tr_s3 + T_W'((1 << FRAC_BITS) - 1) : tr_s3;

	always_ff @(posedge clk) begin
		if (en4) begin
			dc_s4  <= tc_adj[T_W-1:FRAC_BITS];
			dr_s4  <= tr_adj[T_W-1:FRAC_BITS];
			pix_s4 <= pix_s3;
		end
	end

	// Stage 5: bounds check and output register
	assign col_ok = !dc_s4[D_W-1] && (dc_s4 < $signed(D_W'(cfg.width)));
	assign row_ok = !dr_s4[D_W-1] && (dr_s4 < $signed(D_W'(cfg.height)));

	always_ff @(posedge clk) begin
		if (en5) begin
			wr_s5      <= row_ok && col_ok;
			dst_row_s5 <= (row_ok && col_ok) ? dr_s4[COORD_W-1:0] : '0;
			dst_col_s5 <= (row_ok && col_ok) ? dc_s4[COORD_W-1:0] : '0;
			pix_s5     <= pix_s4;
		end
	end

	assign out_valid   = v_s5;
	assign dst_row     = dst_row_s5;
	assign dst_col     = dst_col_s5;
	assign pixel_out   = pix_s5;
	assign write_valid = wr_s5;

	// A flagged write lands inside the frame
	a_write_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && write_valid) |->
		(DIM_W'(dst_row) < cfg.height) && (DIM_W'(dst_col) < cfg.width))
		else $error("flagged destination outside the frame");

	// A dropped write carries a zero address
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !write_valid) |-> (dst_row == '0) && (dst_col == '0))
		else $error("dropped write with nonzero address");

	// An accepted item occupies the first stage
	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted item lost at stage 1");

	// An empty first stage never back-pressures the source
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall)
		else $error("stall with empty first stage");

endmodule

`default_nettype wire

### hw/rtl/rotate_pixel_address_map.sv
// Top level of the forward-mapping rotation address generator.
//
// Usage:
//  Source pixels arrive on the input channel (in_valid / in_stall) with
//  src_row, src_col and pixel_in. Each item yields exactly one item on the
//  output channel (out_valid / out_stall): dst_row, dst_col, pixel_out and
//  write_valid, which is set when the rotated address lies inside the frame.
//  The configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data)
//  sets cosine, sine (Q2.14), frame width and frame height; cfg_ready is
//  always high. Write it only while no items are in flight.
//
//  Accepted items pass through the five-stage datapath, with one multiplier
//  per product, to out_valid; throughput is one item per cycle unless stalled.
//  Reset empties the pipeline and loads cosine 1.0, sine 0 and a 4096 x 4096
//  frame. When the receiver stalls, the output item holds and the stall
//  backs up stage by stage; empty stages still fill, so in_stall rises only
//  once every stage holds an item.
`default_nettype none

module rotate_pixel_address_map (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [rpam_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rpam_pkg::CFG_DAT_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [rpam_pkg::COORD_W-1:0]   src_row,
	input  wire logic [rpam_pkg::COORD_W-1:0]   src_col,
	input  wire logic [rpam_pkg::PIX_W-1:0]     pixel_in,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [rpam_pkg::COORD_W-1:0]        dst_row,
	output logic [rpam_pkg::COORD_W-1:0]        dst_col,
	output logic [rpam_pkg::PIX_W-1:0]          pixel_out,
	output logic                                write_valid
);
	import rpam_pkg::*;

	rpam_cfg_t cfg;

	// Configuration registers
	rpam_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Address datapath
	rpam_pipe u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.src_row     (src_row),
		.src_col     (src_col),
		.pixel_in    (pixel_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.dst_row     (dst_row),
		.dst_col     (dst_col),
		.pixel_out   (pixel_out),
		.write_valid (write_valid)
	);

endmodule

`default_nettype wire

### tb/tb_rotate_pixel_address_map.sv
// Testbench for the rotation address mapper: directed and random pixels checked against a predictor.
`default_nettype none

module tb_rotate_pixel_address_map;
	import rpam_pkg::*;

	// One destination item as the block emits it
	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [PIX_W-1:0]   pix;
		logic               wr;
	} dest_pixel_t;

	localparam int     CLK_HALF     = 4;
	localparam longint RUN_LIMIT    = 4000000;
	localparam int     FLUSH_CYCLES = 16;
	localparam int     HOLD_CYCLES  = 240;
	localparam int     PHASES       = 14;
	localparam int     PHASE_ITEMS  = 60;
	localparam int     LAST_ITEMS   = 70;
	localparam int     COORD_MAX    = (1 << COORD_W) - 1;
	localparam int     IDX_MAX      = (1 << CFG_IDX_W) - 1;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [COORD_W-1:0]   src_row   = '0;
	logic [COORD_W-1:0]   src_col   = '0;
	logic [PIX_W-1:0]     pixel_in  = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [COORD_W-1:0]   dst_row;
	logic [COORD_W-1:0]   dst_col;
	logic [PIX_W-1:0]     pixel_out;
	logic                 write_valid;

	// Register image held by the predictor
	logic signed [COEF_W-1:0] cos_reg;
	logic signed [COEF_W-1:0] sin_reg;
	logic [DIM_W-1:0]         width_reg;
	logic [DIM_W-1:0]         height_reg;

	dest_pixel_t expected_dest[$];
	int          mismatches  = 0;
	bit          src_idle_on = 1'b1;
	bit          rcv_idle_on = 1'b1;
	int          hold_len    = 0;

	rotate_pixel_address_map DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.src_row(src_row),
		.src_col(src_col),
		.pixel_in(pixel_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.dst_row(dst_row),
		.dst_col(dst_col),
		.pixel_out(pixel_out),
		.write_valid(write_valid)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// Rotate one source address about the frame center, truncating toward zero
	function automatic dest_pixel_t rotate_address(input logic [COORD_W-1:0] row,
			input logic [COORD_W-1:0] col, input logic [PIX_W-1:0] pix);
		dest_pixel_t d;
		longint one, c, s, hw, hh, ox, oy, nx, ny, dc, dr;
		one = longint'(1) << FRAC_BITS;
		c   = cos_reg;
		s   = sin_reg;
		hw  = longint'(width_reg) / 2;
		hh  = longint'(height_reg) / 2;
		ox  = hw - longint'(col);
		oy  = hh - longint'(row);
		nx  = ox * c - oy * s;
		ny  = oy * c + ox * s;
		dc  = (hw * one - nx) / one;
		dr  = (hh * one - ny) / one;
		d.pix = pix;
		d.wr  = dr >= 0 && dr < longint'(height_reg) && dc >= 0 && dc < longint'(width_reg);
		d.row = d.wr ? dr[COORD_W-1:0] : '0;
		d.col = d.wr ? dc[COORD_W-1:0] : '0;
		return d;
	endfunction

	// One register write; valid stays up so writes can go back to back
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		logic [DIM_W-1:0] dim;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		dim = data[DIM_W-1:0];
		if (dim > DIM_W'(MAX_DIM))
			dim = DIM_W'(MAX_DIM);
		case (idx)
			REG_COS:    cos_reg = data;
			REG_SIN:    sin_reg = data;
			REG_WIDTH:  width_reg = dim;
			REG_HEIGHT: height_reg = dim;
			default:    ;
		endcase
	endtask

	// Stop sending and wait until every expected item has come back
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_dest.size() != 0);
	endtask

	task automatic set_frame(input logic [CFG_DAT_W-1:0] c, input logic [CFG_DAT_W-1:0] s,
			input logic [CFG_DAT_W-1:0] w, input logic [CFG_DAT_W-1:0] h);
		drain_pipeline();
		cfg_write(REG_COS, c);
		cfg_write(REG_SIN, s);
		cfg_write(REG_WIDTH, w);
		cfg_write(REG_HEIGHT, h);
		cfg_valid <= 1'b0;
	endtask

	// Offer one pixel, maybe after a gap, and log its expected result on acceptance
	task automatic send_pixel(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
			input logic [PIX_W-1:0] pix);
		dest_pixel_t e;
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		e = rotate_address(row, col, pix);
		in_valid <= 1'b1;
		src_row  <= row;
		src_col  <= col;
		pixel_in <= pix;
		do @(posedge clk); while (in_stall);
		expected_dest.push_back(e);
	endtask

	// Mostly inside the frame, sometimes anywhere in the coordinate range
	task automatic send_random_pixel();
		logic [COORD_W-1:0] r, c;
		if ($urandom_range(0, 7) == 0 || height_reg == 0 || width_reg == 0) begin
			r = COORD_W'($urandom_range(0, COORD_MAX));
			c = COORD_W'($urandom_range(0, COORD_MAX));
		end else begin
			r = COORD_W'($urandom_range(0, height_reg - 1));
			c = COORD_W'($urandom_range(0, width_reg - 1));
		end
		send_pixel(r, c, PIX_W'($urandom_range(0, 16'hFFFF)));
	endtask

	function automatic logic [CFG_DAT_W-1:0] random_side();
		case ($urandom_range(0, 7))
			0:       return CFG_DAT_W'($urandom_range(1, MAX_DIM));
			1:       return $urandom_range(0, 1) ? CFG_DAT_W'(1) : CFG_DAT_W'(0);
			2:       return CFG_DAT_W'($urandom_range(MAX_DIM + 1, 16'hFFFF));
			3:       return CFG_DAT_W'(MAX_DIM);
			default: return CFG_DAT_W'($urandom_range(1, 64));
		endcase
	endfunction

	function automatic logic [CFG_DAT_W-1:0] random_coef();
		case ($urandom_range(0, 4))
			0:       return CFG_DAT_W'(-16384);
			1:       return CFG_DAT_W'(16384);
			2:       return CFG_DAT_W'(0);
			3:       return CFG_DAT_W'($urandom_range(0, 16'hFFFF));
			default: return CFG_DAT_W'(int'($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	// Receiver: random stall bursts, or one long hold when asked
	initial begin : receiver
		int n;
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				out_stall <= 1'b1;
				for (n = 0; n < hold_len; n++)
					@(posedge clk);
				hold_len = 0;
				out_stall <= 1'b0;
			end else if (rcv_idle_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Compare every accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		dest_pixel_t e, got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{dst_row, dst_col, pixel_out, write_valid};
			if (expected_dest.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: row %0d col %0d pixel %h write %0b",
						got.row, got.col, got.pix, got.wr);
			end else begin
				e = expected_dest.pop_front();
				if (got.row !== e.row || got.col !== e.col || got.pix !== e.pix ||
						got.wr !== e.wr) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp row %0d col %0d pixel %h write %0b, got row %0d col %0d pixel %h write %0b",
							e.row, e.col, e.pix, e.wr, got.row, got.col, got.pix, got.wr);
				end
			end
		end
	end

	// Reset values give the identity map over a full 4096 frame
	task automatic test_identity_corners();
		send_pixel(0, 0, 16'h0000);
		send_pixel(COORD_W'(COORD_MAX), COORD_W'(COORD_MAX), 16'hFFFF);
		send_pixel(0, COORD_W'(COORD_MAX), 16'h00FF);
		send_pixel(COORD_W'(COORD_MAX), 0, 16'hFF00);
		send_pixel(2048, 2048, 16'hA5A5);
	endtask

	// Half turn, quarter turns both ways and coefficients at the field limits
	task automatic test_rotation_extremes();
		logic [CFG_DAT_W-1:0] cs[4], sn[4];
		int i;
		cs = '{CFG_DAT_W'(-16384), 16'd0, 16'd0, 16'h8000};
		sn = '{16'd0, CFG_DAT_W'(16384), CFG_DAT_W'(-16384), 16'h7FFF};
		for (i = 0; i < 4; i++) begin
			set_frame(cs[i], sn[i], 64, 48);
			send_pixel(0, 0, PIX_W'($urandom_range(0, 16'hFFFF)));
			send_pixel(47, 63, PIX_W'($urandom_range(0, 16'hFFFF)));
			send_pixel(10, 37, PIX_W'($urandom_range(0, 16'hFFFF)));
		end
	endtask

	// Zero, one-pixel and oversized frame sides; sources beyond the frame
	task automatic test_frame_sizes();
		set_frame(16384, 0, 0, 16);
		send_pixel(0, 0, 16'h1234);
		set_frame(16384, 0, 1, 1);
		send_pixel(0, 0, 16'h5678);
		send_pixel(1, 1, 16'h9ABC);
		set_frame(16384, 0, 16'hFFFF, 16'h2003);
		send_pixel(5, COORD_W'(COORD_MAX), 16'hDEF0);
		send_pixel(2, 100, 16'h0F0F);
	endtask

	// Writes to indexes past the last register change nothing
	task automatic test_unknown_index();
		drain_pipeline();
		cfg_write(CFG_IDX_W'(REG_HEIGHT + 1), 16'hFFFF);
		cfg_write(CFG_IDX_W'(IDX_MAX), 16'h8000);
		cfg_write(CFG_IDX_W'($urandom_range(REG_HEIGHT + 1, IDX_MAX)),
			CFG_DAT_W'($urandom_range(0, 16'hFFFF)));
		cfg_valid <= 1'b0;
		send_pixel(1, 5, 16'h3C3C);
		send_pixel(0, 4095, 16'hC3C3);
	endtask

	// Receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_backpressure();
		set_frame(CFG_DAT_W'(11585), CFG_DAT_W'(11585), 40, 30);
		src_idle_on = 1'b0;
		rcv_idle_on = 1'b0;
		hold_len = HOLD_CYCLES;
		repeat (40) send_random_pixel();
		drain_pipeline();
	endtask

	// Random frames and angles, each phase starting from an empty pipeline
	task automatic test_random_frames();
		int p;
		for (p = 0; p < PHASES; p++) begin
			set_frame(random_coef(), random_coef(), random_side(), random_side());
			src_idle_on = $urandom_range(0, 3) != 0;
			rcv_idle_on = $urandom_range(0, 3) != 0;
			repeat (PHASE_ITEMS) begin
				send_random_pixel();
				if ($urandom_range(0, 99) == 0)
					drain_pipeline();
			end
		end
		// last stretch with neither side idling
		set_frame(CFG_DAT_W'(-11585), CFG_DAT_W'(11585), 96, 80);
		src_idle_on = 1'b0;
		rcv_idle_on = 1'b0;
		repeat (LAST_ITEMS) send_random_pixel();
	endtask

	initial begin
		cos_reg    = COS_RESET;
		sin_reg    = SIN_RESET;
		width_reg  = DIM_RESET;
		height_reg = DIM_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_identity_corners();
		test_rotation_extremes();
		test_frame_sizes();
		test_unknown_index();
		test_backpressure();
		test_random_frames();
		drain_pipeline();
		repeat (FLUSH_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_dest.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/rpam_pkg.sv
hw/rtl/rpam_cfg.sv
hw/rtl/rpam_pipe.sv
hw/rtl/rotate_pixel_address_map.sv
tb/tb_rotate_pixel_address_map.sv
